// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on a given clock, disabled while the active-low reset is low.
`define GLU_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property on the house clock and reset names.
`define GLU_ASSERT(lbl, prop, msg) \
  `GLU_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: sv/glu_pkg.sv
// ----------------------------------------------------------------------------
// GCD/LCM unit package
// Shared types and codes for the gcd/lcm datapath and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package glu_pkg;

  // Result status carried with every result word
  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_ZERO     = 2'd1,
    ERR_OVERFLOW = 2'd2
  } glu_err_e;

  // Operations of the shared adder/subtractor
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } glu_alu_op_e;

  // Sequencer status seen by the top level
  typedef struct packed {
    logic idle;
    logic done;
  } glu_status_t;

endpackage

`default_nettype wire

// File: sv/glu_if.sv
// ----------------------------------------------------------------------------
// GCD/LCM channel interfaces
// Valid/ready channels for operand words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface glu_in_if #(
  parameter int unsigned DATA_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] first_operand;
  logic signed [DATA_WIDTH-1:0] second_operand;

  modport source (output valid, output first_operand, output second_operand, input ready);
  modport sink   (input valid, input first_operand, input second_operand, output ready);
endinterface

interface glu_out_if #(
  parameter int unsigned DATA_WIDTH = 32
) ();
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] gcd_value;
  logic [DATA_WIDTH-2:0] lcm_value;
  glu_pkg::glu_err_e     error_code;

  modport source (output valid, output gcd_value, output lcm_value, output error_code,
                  input ready);
  modport sink   (input valid, input gcd_value, input lcm_value, input error_code,
                  output ready);
endinterface

`default_nettype wire

// File: sv/gcd_lcm_unit.sv
// ----------------------------------------------------------------------------
// GCD/LCM unit
// Greatest common divisor and exact least common multiple of two signed words.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Fields                                   | Word accepted
//  --------+-----+------------------------------------------+--------------------
//  in_i    | in  | first_operand, second_operand            | valid && ready
//  out_o   | out | gcd_value, lcm_value, error_code         | valid && ready
//
//  Flow: one operand word runs the binary gcd loop (one subtract, halve or
//    swap per cycle), the restore of the common power of two, the restoring
//    divide and the shift-add multiply, which stops early on overflow. Adds
//    and subtracts all go through the single shared add/subtract unit. A
//    zero operand goes straight to the done state.
//  Reset: rst_ni clears the sequencer and the output valid flag only.
//  Stalls: the result sits in the output register; a new word is taken once
//    the sequencer has handed its result over, even while out_o is stalled.
//
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_lcm_unit #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  glu_in_if.sink    in_i,
  glu_out_if.source out_o
);
  import glu_pkg::*;

  glu_status_t            status;
  logic                   start, take;
  logic [DATA_WIDTH-1:0]  mag_a, mag_b;
  logic [DATA_WIDTH-1:0]  core_gcd;
  logic [DATA_WIDTH-2:0]  core_lcm;
  glu_err_e               core_err;

  logic                   out_valid_q;
  logic [DATA_WIDTH-1:0]  gcd_q;
  logic [DATA_WIDTH-2:0]  lcm_q;
  glu_err_e               err_q;

  // Magnitudes; the most negative value maps to 2^(DATA_WIDTH-1) unsigned
  assign mag_a = in_i.first_operand[DATA_WIDTH-1]
               ? (~in_i.first_operand + 1'b1) : in_i.first_operand;
  assign mag_b = in_i.second_operand[DATA_WIDTH-1]
               ? (~in_i.second_operand + 1'b1) : in_i.second_operand;

  // Take a new word only while the sequencer is idle
  assign in_i.ready = status.idle;
  assign start      = in_i.valid & status.idle;

  // Hand the result over when the output register is free or draining
  assign take = status.done & (~out_valid_q | out_o.ready);

  glu_core #(.DATA_WIDTH(DATA_WIDTH)) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .take_i   (take),
    .mag_a_i  (mag_a),
    .mag_b_i  (mag_b),
    .status_o (status),
    .gcd_o    (core_gcd),
    .lcm_o    (core_lcm),
    .err_o    (core_err)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
      gcd_q       <= core_gcd;
      lcm_q       <= core_lcm;
      err_q       <= core_err;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.gcd_value  = gcd_q;
  assign out_o.lcm_value  = lcm_q;
  assign out_o.error_code = err_q;

endmodule

`default_nettype wire

// File: sv/glu_alu.sv
// ----------------------------------------------------------------------------
// GCD/LCM shared arithmetic unit
// One add/subtract datapath reused by the add and subtract steps of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module glu_alu #(
  parameter int unsigned WIDTH = 33
) (
  input  glu_pkg::glu_alu_op_e op_i,
  input  logic [WIDTH-1:0]     a_i,
  input  logic [WIDTH-1:0]     b_i,
  output logic [WIDTH-1:0]     res_o
);
  import glu_pkg::*;

  always_comb begin
    unique case (op_i)
      ALU_ADD: res_o = a_i + b_i;
      ALU_SUB: res_o = a_i - b_i;
      default: res_o = a_i + b_i;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/glu_core.sv
// ----------------------------------------------------------------------------
// GCD/LCM sequencer
// Binary gcd, restoring division and shift-add multiply on one shared unit.
// ----------------------------------------------------------------------------
`default_nettype none

module glu_core #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    take_i,
  input  logic [DATA_WIDTH-1:0]   mag_a_i,
  input  logic [DATA_WIDTH-1:0]   mag_b_i,
  output glu_pkg::glu_status_t    status_o,
  output logic [DATA_WIDTH-1:0]   gcd_o,
  output logic [DATA_WIDTH-2:0]   lcm_o,
  output glu_pkg::glu_err_e       err_o
);
  import glu_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned AW = DATA_WIDTH + 1;
  localparam int unsigned KW = $clog2(DATA_WIDTH + 1);
  localparam int unsigned CW = $clog2(DATA_WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_SHIFT,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_e;

  state_e          state_q;
  logic [W-1:0]    ma_q, mb_q;
  logic [W-1:0]    x_q, y_q;     // gcd operands, then quotient / multiplier shifters
  logic [KW-1:0]   k_q;          // common power of two
  logic [CW-1:0]   cnt_q;        // bit counter for divide and multiply
  logic [W-1:0]    rem_q;        // remainder, then product accumulator
  logic [W-1:0]    g_q;
  logic [W-2:0]    lcm_q;
  glu_err_e        err_q;

  glu_alu_op_e     alu_op;
  logic [AW-1:0]   alu_a, alu_b, alu_res;

  glu_alu #(.WIDTH(AW)) u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  // Operand steering for the shared unit
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state_q)
      ST_GCD: begin
        alu_op = ALU_SUB;
        alu_a  = {1'b0, x_q};
        alu_b  = {1'b0, y_q};
      end
      ST_DIV: begin
        alu_op = ALU_SUB;
        alu_a  = {rem_q[W-1:0], x_q[W-1]};
        alu_b  = {1'b0, g_q};
      end
      ST_MUL: begin
        alu_op = ALU_ADD;
        alu_a  = {rem_q[W-1:0], 1'b0};
        alu_b  = y_q[W-1] ? {1'b0, x_q} : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            ma_q <= mag_a_i;
            mb_q <= mag_b_i;
            x_q  <= mag_a_i;
            y_q  <= mag_b_i;
            k_q  <= '0;
            if (mag_a_i == '0 || mag_b_i == '0) begin
              g_q     <= mag_a_i | mag_b_i;
              lcm_q   <= '0;
              err_q   <= ERR_ZERO;
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_GCD;
            end
          end
        end
        ST_GCD: begin
          if (!x_q[0] && !y_q[0]) begin
            x_q <= x_q >> 1;
            y_q <= y_q >> 1;
            k_q <= k_q + KW'(1);
          end else if (!x_q[0]) begin
            x_q <= x_q >> 1;
          end else if (!y_q[0]) begin
            y_q <= y_q >> 1;
          end else if (alu_res == '0) begin
            state_q <= ST_SHIFT;
          end else if (!alu_res[W]) begin
            x_q <= alu_res[W:1];
          end else begin
            // x below y: swap, subtract next cycle
            x_q <= y_q;
            y_q <= x_q;
          end
        end
        ST_SHIFT: begin
          if (k_q == '0) begin
            g_q     <= x_q;
            x_q     <= ma_q;
            rem_q   <= '0;
            cnt_q   <= CW'(DATA_WIDTH - 1);
            state_q <= ST_DIV;
          end else begin
            x_q <= x_q << 1;
            k_q <= k_q - KW'(1);
          end
        end
        ST_DIV: begin
          // restore when the trial subtract borrows
          rem_q <= alu_res[W] ? alu_a[W-1:0] : alu_res[W-1:0];
          x_q   <= {x_q[W-2:0], ~alu_res[W]};
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == '0) begin
            y_q     <= mb_q;
            rem_q   <= '0;
            cnt_q   <= CW'(DATA_WIDTH - 1);
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          rem_q <= alu_res[W-1:0];
          y_q   <= y_q << 1;
          cnt_q <= cnt_q - CW'(1);
          // the accumulator only grows, so crossing the limit is final
          if (alu_res[W] || alu_res[W-1]) begin
            lcm_q   <= '0;
            err_q   <= ERR_OVERFLOW;
            state_q <= ST_DONE;
          end else if (cnt_q == '0) begin
            lcm_q   <= alu_res[W-2:0];
            err_q   <= ERR_OK;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (take_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign status_o.idle = (state_q == ST_IDLE);
  assign status_o.done = (state_q == ST_DONE);
  assign gcd_o         = g_q;
  assign lcm_o         = lcm_q;
  assign err_o         = err_q;

endmodule

`default_nettype wire

// File: sv/gcd_lcm_unit_checker.sv
// ----------------------------------------------------------------------------
// GCD/LCM unit checker
// Port-level assertions on the gcd/lcm unit, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gcd_lcm_unit_checker #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] gcd_value,
  input logic [DATA_WIDTH-2:0] lcm_value,
  input logic [1:0]            error_code
);
  import glu_pkg::*;

  // any error clears the lcm
  property p_err_lcm_zero;
    (out_valid && error_code != ERR_OK) |-> (lcm_value == '0);
  endproperty

  // a clean result has nonzero gcd and lcm
  property p_ok_nonzero;
    (out_valid && error_code == ERR_OK) |-> (gcd_value != '0 && lcm_value != '0);
  endproperty

  // stalled result holds
  property p_out_hold;
    (out_valid && !out_ready) |=>
      (out_valid && $stable(gcd_value) && $stable(lcm_value) && $stable(error_code));
  endproperty

  // busy after taking a word
  `GLU_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "ready after accept")

  `GLU_ASSERT(a_err_lcm_zero, p_err_lcm_zero, "lcm not zero on error")

  `GLU_ASSERT(a_ok_nonzero, p_ok_nonzero, "zero result without error")

  `GLU_ASSERT(a_out_hold, p_out_hold, "stalled result changed")

endmodule

bind gcd_lcm_unit gcd_lcm_unit_checker #(.DATA_WIDTH(DATA_WIDTH)) u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .gcd_value  (out_o.gcd_value),
  .lcm_value  (out_o.lcm_value),
  .error_code (out_o.error_code)
);

`default_nettype wire

// File: tb/tb_gcd_lcm_unit.sv
// ----------------------------------------------------------------------------
// GCD/LCM unit testbench
// Sends operand words through the input channel and checks each result word
// (gcd, lcm and status) against a local gcd/lcm calculation. The sender and
// receiver idle at random, the receiver also holds off for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_gcd_lcm_unit;
  import glu_pkg::*;

  localparam int unsigned DW          = 32;
  localparam int unsigned WATCHDOG_MAX = 6000;  // cycles with no word accepted
  localparam int unsigned TAIL_CYCLES  = 300;   // well over one worst-case word
  localparam int unsigned HOLD_CYCLES  = 600;   // long receiver hold-off
  localparam int unsigned MAX_PRINTS   = 40;

  localparam logic [DW-1:0] MIN_WORD = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] MAX_WORD = {1'b0, {(DW-1){1'b1}}};

  // Who idles, and how often (percent of cycles)
  typedef enum logic [1:0] {
    PACE_SLOW_SINK,    // sender idles 11, receiver 63
    PACE_SLOW_SOURCE,  // sender idles 63, receiver 11
    PACE_FULL          // nobody idles
  } pace_e;

  typedef struct packed {
    logic [DW-1:0] gcd;
    logic [DW-2:0] lcm;
    glu_err_e      err;
  } gcd_lcm_t;

  logic clk = 1'b0;
  logic rst_n;

  glu_in_if  #(.DATA_WIDTH(DW)) in_if ();
  glu_out_if #(.DATA_WIDTH(DW)) out_if ();

  gcd_lcm_unit #(
    .DATA_WIDTH(DW)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  gcd_lcm_t    pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned words_checked  = 0;
  int unsigned hold_left      = 0;
  pace_e       pace           = PACE_SLOW_SINK;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Expected word for one operand pair: gcd of the magnitudes by Euclid,
  // exact lcm, zero status ahead of overflow status.
  // --------------------------------------------------------------------------
  function automatic gcd_lcm_t calc_gcd_lcm(logic [DW-1:0] a, logic [DW-1:0] b);
    logic [63:0] mag_a;
    logic [63:0] mag_b;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] r;
    logic [63:0] quo;
    logic [63:0] lim;
    logic [63:0] prod;
    gcd_lcm_t    res;
    // The most negative word keeps its magnitude 2^(DW-1) as unsigned
    mag_a = {32'd0, a[DW-1] ? (~a + 1'b1) : a};
    mag_b = {32'd0, b[DW-1] ? (~b + 1'b1) : b};
    x = mag_a;
    y = mag_b;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    lim     = {33'd0, {(DW-1){1'b1}}};
    res.gcd = x[DW-1:0];
    res.lcm = '0;
    res.err = ERR_OK;
    if (mag_a == 0 || mag_b == 0) begin
      res.err = ERR_ZERO;
    end else begin
      quo = mag_a / x;
      if (mag_b > lim / quo) begin
        res.err = ERR_OVERFLOW;
      end else begin
        prod    = (quo * mag_b) & lim;
        res.lcm = prod[DW-2:0];
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Print one line per mismatch (up to a cap) and count all of them.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < MAX_PRINTS) begin
      $display("%0t: mismatch on %s, result word %0d: got 0x%0h, want 0x%0h",
               $realtime, what, words_checked, got, want);
    end
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Send one operand word. Called right after a rising edge; returns at the
  // edge that accepted it, with valid still high so the next word can follow
  // back to back.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [DW-1:0] a, input logic [DW-1:0] b);
    int unsigned idle_pct;
    idle_pct = (pace == PACE_SLOW_SINK) ? 11 : (pace == PACE_SLOW_SOURCE) ? 63 : 0;
    // Insert sender gaps, drawing again after each idle clock
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.first_operand  <= a;
    in_if.second_operand <= b;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    pending_results.push_back(calc_gcd_lcm(a, b));
  endtask

  // Drop valid and hold until every expected result word has come back
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random sign on a magnitude
  function automatic logic [DW-1:0] with_sign(logic [DW-1:0] mag);
    return $urandom_range(1) ? (~mag + 1'b1) : mag;
  endfunction

  // One random operand word of a given flavor
  function automatic logic [DW-1:0] pick_operand(int unsigned kind);
    case (kind)
      0:       return $urandom;
      1:       return with_sign($urandom_range(255));
      2:       return with_sign(DW'(1) << $urandom_range(DW - 1));
      3:       return with_sign($urandom >> $urandom_range(DW - 1));
      default: begin
        case ($urandom_range(4))
          0:       return '0;
          1:       return MIN_WORD;
          2:       return MAX_WORD;
          3:       return {DW{1'b1}};
          default: return 1;
        endcase
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Extremes, zero operands, most negative word, overflow edges, long Euclid
  task automatic test_directed();
    send_word(0, 0);
    send_word(0, 5);
    send_word(-7, 0);
    send_word(MIN_WORD, 0);
    send_word(MIN_WORD, MIN_WORD);
    send_word(MIN_WORD, 2);
    send_word(MIN_WORD, -1);
    send_word(1, MIN_WORD);
    send_word(MAX_WORD, MAX_WORD);
    send_word(MAX_WORD, 1);
    send_word(MAX_WORD, MAX_WORD - 1);
    send_word(-MAX_WORD, MIN_WORD);
    send_word(1, 1);
    send_word(-1, -1);
    send_word(12, 18);
    send_word(-12, 18);
    send_word(12, -18);
    send_word(46341, 46340);
    send_word(46341, 46341);
    send_word(65536, 32768);
    send_word(32'h4000_0000, 2);
    send_word(32'h4000_0000, 3);
    send_word(1836311903, 1134903170);
    send_word(-1836311903, -1134903170);
    wait_for_results();
  endtask

  // Random words: four in ten are pairs sharing a factor so the lcm lands on both
  // sides of the overflow edge, the rest from the other flavors.
  task automatic test_random(input int unsigned count, input pace_e mode);
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic [DW-1:0] fac;
    pace = mode;
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(9) < 4) begin
        fac = $urandom_range(1, 65535);
        a   = with_sign(fac * $urandom_range(1, 32767));
        b   = with_sign(fac * $urandom_range(1, 32767));
      end else begin
        a = pick_operand($urandom_range(4));
        b = pick_operand($urandom_range(4));
      end
      send_word(a, b);
    end
    wait_for_results();
  endtask

  // Hold the receiver off while words keep coming, so the block fills up and
  // stalls its input; then let it drain.
  task automatic test_backpressure();
    pace      = PACE_FULL;
    hold_left = HOLD_CYCLES;
    for (int unsigned n = 0; n < 8; n++) begin
      send_word($urandom, with_sign($urandom_range(1, 1000)));
    end
    wait_for_results();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random ready per pace, or a long hold-off when one is requested
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else begin
      case (pace)
        PACE_SLOW_SINK:   out_if.ready <= ($urandom_range(99) >= 63);
        PACE_SLOW_SOURCE: out_if.ready <= ($urandom_range(99) >= 11);
        default:          out_if.ready <= 1'b1;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result check: compare each accepted word with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    gcd_lcm_t want;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", 64'(out_if.gcd_value), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_if.gcd_value !== want.gcd) begin
          report_mismatch("gcd_value", 64'(out_if.gcd_value), 64'(want.gcd));
        end
        if (out_if.lcm_value !== want.lcm) begin
          report_mismatch("lcm_value", 64'(out_if.lcm_value), 64'(want.lcm));
        end
        if (out_if.error_code !== want.err) begin
          report_mismatch("error_code", 64'(out_if.error_code), 64'(want.err));
        end
      end
      words_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: give up after a long run of cycles with no word accepted
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    static int unsigned quiet_cycles = 0;
    if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("%0t: no word accepted for %0d cycles", $realtime, WATCHDOG_MAX);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_if.valid          = 1'b0;
    in_if.first_operand  = '0;
    in_if.second_operand = '0;
    rst_n                = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(380, PACE_SLOW_SINK);
    test_backpressure();
    test_random(380, PACE_SLOW_SOURCE);
    test_random(380, PACE_FULL);

    // Let any stray word show up before the verdict
    in_if.valid <= 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
